// ===== rtl/ssli_pkg.sv =====
// Package for the sorted score list: sizes, the record type and the result codes.
// Used by every module of the block; it depends on nothing else.
package ssli_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W     = 32;
  localparam int unsigned SCORE_W  = 16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REFUSED  = 2'd1,
    KIND_ENTRY    = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } rec_t;

endpackage

// ===== rtl/ssli_cell.sv =====
// One cell of the sorted chain: holds a record and its valid flag.
// Depends on ssli_pkg for the record type.
module ssli_cell import ssli_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ins_i,
  input  rec_t new_rec_i,
  input  rec_t left_rec_i,
  input  logic left_valid_i,
  input  logic left_gt_i,
  output logic gt_o,
  output rec_t rec_o,
  output logic valid_o
);

  rec_t rec_q, rec_d;
  logic valid_q, valid_d;

  // An empty cell sorts after every key, so the flags form a suffix of the chain.
  assign gt_o = !valid_q || (rec_q.score > new_rec_i.score) ||
                ((rec_q.score == new_rec_i.score) && (rec_q.id > new_rec_i.id));

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ins_i && gt_o) begin
      if (left_gt_i) begin
        rec_d   = left_rec_i;
        valid_d = left_valid_i;
      end else begin
        rec_d   = new_rec_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/ssli_chain.sv =====
// Row of sorted cells with a read port selecting one entry by index.
// Depends on ssli_pkg and ssli_cell.
module ssli_chain import ssli_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ins_i,
  input  rec_t             new_rec_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output rec_t             rd_rec_o
);

  rec_t cell_rec [CAPACITY];
  logic cell_vld [CAPACITY];
  logic cell_gt  [CAPACITY];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_head
      ssli_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ins_i        (ins_i),
        .new_rec_i    (new_rec_i),
        .left_rec_i   (new_rec_i),
        .left_valid_i (1'b1),
        .left_gt_i    (1'b0),
        .gt_o         (cell_gt[k]),
        .rec_o        (cell_rec[k]),
        .valid_o      (cell_vld[k])
      );
    end else begin : g_body
      ssli_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ins_i        (ins_i),
        .new_rec_i    (new_rec_i),
        .left_rec_i   (cell_rec[k-1]),
        .left_valid_i (cell_vld[k-1]),
        .left_gt_i    (cell_gt[k-1]),
        .gt_o         (cell_gt[k]),
        .rec_o        (cell_rec[k]),
        .valid_o      (cell_vld[k])
      );
    end
  end

  assign rd_rec_o = cell_rec[rd_idx_i];

endmodule

// ===== rtl/sorted_score_list_insert.sv =====
// Sorted score list top level: control, entry count and the output register.
// Depends on ssli_pkg and ssli_chain.
// An insert gives its result beat in the next cycle. A readout gives one beat
// per cycle while not stalled, count beats in all (one empty beat if count is 0),
// from the output register; no new item is taken until its last beat is loaded.
// Reset clears every cell's valid flag and the count, so the table starts empty.
module sorted_score_list_insert import ssli_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [ID_W-1:0]    student_id_i,
  input  logic [SCORE_W-1:0] score_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [ID_W-1:0]    entry_id_o,
  output logic [SCORE_W-1:0] entry_score_o,
  output logic               last_o
);

  logic             busy_q, busy_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  kind_e            kind_q, kind_d;
  rec_t             out_rec_q, out_rec_d;
  logic             last_q, last_d;

  logic out_free, accept, full, ins, rd_last;
  rec_t new_rec, rd_rec;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !busy_q && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign ins        = accept && (func_i == FUNC_INSERT) && !full;
  assign rd_last    = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q);

  assign new_rec.id    = student_id_i;
  assign new_rec.score = score_i;

  ssli_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_i     (ins),
    .new_rec_i (new_rec),
    .rd_idx_i  (rd_idx_q),
    .rd_rec_o  (rd_rec)
  );

  always_comb begin
    busy_d      = busy_q;
    rd_idx_d    = rd_idx_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    out_rec_d   = out_rec_q;
    last_d      = last_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_rec_d   = '0;
      last_d      = 1'b1;
      if (func_i == FUNC_INSERT) begin
        if (full) begin
          kind_d = KIND_REFUSED;
        end else begin
          kind_d  = KIND_ACCEPTED;
          count_d = count_q + CNT_W'(1);
        end
      end else if (count_q == '0) begin
        kind_d = KIND_EMPTY;
      end else begin
        out_valid_d = out_valid_q && !out_ready_i;
        busy_d      = 1'b1;
        rd_idx_d    = '0;
      end
    end else if (busy_q && out_free) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_ENTRY;
      out_rec_d   = rd_rec;
      last_d      = rd_last;
      if (rd_last) begin
        busy_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rd_idx_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rd_idx_q    <= rd_idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    out_rec_q <= out_rec_d;
    last_q    <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign entry_id_o    = out_rec_q.id;
  assign entry_score_o = out_rec_q.score;
  assign last_o        = last_q;

endmodule
